>>> rtl/albs_pkg.sv
// types, constants and register map of the alarm light and buzzer sequencer
`timescale 1ns / 1ps

package albs_pkg;

    localparam int TICK_W  = 16;
    localparam int PHASE_W = 3;
    localparam int MUTE_W  = 8;
    localparam int MODE_W  = 2;
    localparam int MENU_W  = 8;
    localparam int CFG_AW  = 3;
    localparam int CFG_DW  = 16;

    localparam logic [MODE_W-1:0]  MODE_NONE     = 2'd0;
    localparam logic [MODE_W-1:0]  MODE_SOUNDING = 2'd1;
    localparam logic [MODE_W-1:0]  MODE_SLOW     = 2'd2;
    localparam logic [MODE_W-1:0]  MODE_SILENT   = 2'd3;

    localparam logic [MENU_W-1:0]  MENU_HOME      = 8'd1;
    localparam logic [PHASE_W-1:0] PHASE_BUZZ_ON  = 3'd1;
    localparam logic [PHASE_W-1:0] PHASE_BUZZ_OFF = 3'd4;
    localparam logic [PHASE_W-1:0] PHASE_LAST     = 3'd5;

    localparam logic [TICK_W-1:0] RST_PHASE_TICKS  = 16'd120;
    localparam logic [MUTE_W-1:0] RST_MUTE_PHASES  = 8'd45;
    localparam logic [TICK_W-1:0] RST_TONE_TICKS   = 16'd500;
    localparam logic [TICK_W-1:0] RST_SLOW_ON      = 16'd1200;
    localparam logic [TICK_W-1:0] RST_SLOW_PERIOD  = 16'd1600;

    typedef enum logic [CFG_AW-1:0] {
        REG_PHASE_TICKS = 3'd0,
        REG_MUTE_PHASES = 3'd1,
        REG_TONE_TICKS  = 3'd2,
        REG_SLOW_ON     = 3'd3,
        REG_SLOW_PERIOD = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [TICK_W-1:0] phase_ticks;
        logic [MUTE_W-1:0] mute_phases;
        logic [TICK_W-1:0] tone_ticks;
        logic [TICK_W-1:0] slow_on;
        logic [TICK_W-1:0] slow_period;
    } t_cfg;

    typedef struct packed {
        logic [TICK_W-1:0]  tick_count;
        logic [PHASE_W-1:0] phase_count;
        logic [MUTE_W-1:0]  mute_phase_count;
        logic [TICK_W-1:0]  slow_count;
        logic               mute_active;
        logic               tone_active;
        logic               light_level;
        logic               buzzer_level;
    } t_state;

    typedef struct packed {
        logic [MODE_W-1:0] alarm_mode;
        logic [MENU_W-1:0] menu_state;
        logic              key_ack;
        logic              tone_start;
    } t_tick;

endpackage

>>> rtl/albs_tick.sv
// next-state logic for one timer tick
`timescale 1ns / 1ps

module albs_tick (
    input  albs_pkg::t_cfg   i_cfg,
    input  albs_pkg::t_state i_state,
    input  albs_pkg::t_tick  i_tick,
    output albs_pkg::t_state o_state
);
    import albs_pkg::*;

    t_state s;
    logic [TICK_W-1:0] tick_inc;
    logic [TICK_W-1:0] slow_inc;
    logic [MUTE_W-1:0] mute_inc;
    logic              blink;

    always_comb begin
        s = i_state;
        if (i_tick.key_ack) begin
            s.mute_active = 1'b1;
        end
        if (i_tick.tone_start) begin
            s.tone_active = 1'b1;
        end
        tick_inc = s.tick_count + TICK_W'(1);
        slow_inc = s.slow_count + TICK_W'(1);
        mute_inc = s.mute_phase_count + MUTE_W'(1);
        blink    = (i_tick.alarm_mode == MODE_SOUNDING) || (i_tick.alarm_mode == MODE_SILENT);

        if (blink) begin
            s.tick_count = tick_inc;
            if (tick_inc >= i_cfg.phase_ticks) begin
                s.tick_count  = '0;
                s.phase_count = s.phase_count + PHASE_W'(1);
                if (s.mute_active) begin
                    s.mute_phase_count = mute_inc;
                    if (mute_inc >= i_cfg.mute_phases) begin
                        s.mute_phase_count = '0;
                        s.mute_active      = 1'b0;
                    end
                end
            end
            s.light_level = !(!s.phase_count[0] && (i_tick.menu_state == MENU_HOME)
                              && !s.mute_active);
            if (i_tick.alarm_mode == MODE_SOUNDING) begin
                if (s.phase_count == PHASE_BUZZ_ON) begin
                    s.buzzer_level = 1'b1;
                end else if (s.phase_count == PHASE_BUZZ_OFF) begin
                    s.buzzer_level = 1'b0;
                end
            end else begin
                s.buzzer_level = 1'b0;
            end
            if (s.phase_count == PHASE_LAST) begin
                s.phase_count = '0;
            end
        end else if (i_tick.alarm_mode == MODE_SLOW) begin
            s.slow_count = slow_inc;
            if (slow_inc > i_cfg.slow_on) begin
                s.buzzer_level = 1'b1;
                s.light_level  = 1'b0;
            end
            if (slow_inc > i_cfg.slow_period) begin
                s.buzzer_level = 1'b0;
                s.light_level  = 1'b1;
                s.slow_count   = '0;
            end
        end else if (s.tone_active) begin
            s.tick_count   = tick_inc;
            s.buzzer_level = 1'b1;
            if (tick_inc > i_cfg.tone_ticks) begin
                s.buzzer_level = 1'b0;
                s.tick_count   = '0;
                s.tone_active  = 1'b0;
            end
        end else begin
            s.light_level  = 1'b1;
            s.buzzer_level = 1'b0;
            s.tick_count   = '0;
        end
        o_state = s;
    end

endmodule

>>> rtl/alarm_light_buzzer_sequencer.sv
// top level of the alarm light and buzzer sequencer
//
// channel | direction | handshake                | payload
// in      | input     | i_in_valid / o_in_ready  | alarm_mode, menu_state, key_ack, tone_start
// out     | output    | o_out_valid / i_out_ready| light_on, buzzer_on, muted, tone_busy
// cfg     | input     | i_cfg_wr_en              | i_cfg_addr, i_cfg_wdata
//
// an input beat passes the input register, then the result register, before its result beat
// one beat per cycle while results are taken; the tick logic is between the two registers
// a full result register stalls the input register, which stalls the input side
// synchronous active-low reset clears state, valid flags and config to defaults
`timescale 1ns / 1ps

module alarm_light_buzzer_sequencer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [albs_pkg::CFG_AW-1:0]   i_cfg_addr,
    input  logic [albs_pkg::CFG_DW-1:0]   i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [albs_pkg::MODE_W-1:0]   i_alarm_mode,
    input  logic [albs_pkg::MENU_W-1:0]   i_menu_state,
    input  logic                          i_key_ack,
    input  logic                          i_tone_start,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_light_on,
    output logic                          o_buzzer_on,
    output logic                          o_muted,
    output logic                          o_tone_busy
);
    import albs_pkg::*;

    t_cfg   r_cfg;
    t_state r_state;
    t_state n_state;
    t_tick  r_tick;
    logic   r_in_valid;
    logic   r_out_valid;
    logic   advance;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.phase_ticks <= RST_PHASE_TICKS;
            r_cfg.mute_phases <= RST_MUTE_PHASES;
            r_cfg.tone_ticks  <= RST_TONE_TICKS;
            r_cfg.slow_on     <= RST_SLOW_ON;
            r_cfg.slow_period <= RST_SLOW_PERIOD;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                REG_PHASE_TICKS: r_cfg.phase_ticks <= i_cfg_wdata;
                REG_MUTE_PHASES: r_cfg.mute_phases <= i_cfg_wdata[MUTE_W-1:0];
                REG_TONE_TICKS:  r_cfg.tone_ticks  <= i_cfg_wdata;
                REG_SLOW_ON:     r_cfg.slow_on     <= i_cfg_wdata;
                REG_SLOW_PERIOD: r_cfg.slow_period <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_tick.alarm_mode <= i_alarm_mode;
            r_tick.menu_state <= i_menu_state;
            r_tick.key_ack    <= i_key_ack;
            r_tick.tone_start <= i_tone_start;
        end
    end

    albs_tick u_tick (
        .i_cfg   (r_cfg),
        .i_state (r_state),
        .i_tick  (r_tick),
        .o_state (n_state)
    );

    // sequencer state, result levels are read straight from it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.tick_count       <= '0;
            r_state.phase_count      <= '0;
            r_state.mute_phase_count <= '0;
            r_state.slow_count       <= '0;
            r_state.mute_active      <= 1'b0;
            r_state.tone_active      <= 1'b0;
            r_state.light_level      <= 1'b1;
            r_state.buzzer_level     <= 1'b0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_light_on  = r_state.light_level;
    assign o_buzzer_on = r_state.buzzer_level;
    assign o_muted     = r_state.mute_active;
    assign o_tone_busy = r_state.tone_active;

endmodule

>>> dv/albs_level_checker.sv
// checker for the alarm light and buzzer sequencer: tracks config, predicts levels, compares beats
`timescale 1ns / 1ps

module albs_level_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [albs_pkg::CFG_AW-1:0] i_cfg_addr,
    input  logic [albs_pkg::CFG_DW-1:0] i_cfg_wdata,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic [albs_pkg::MODE_W-1:0] i_alarm_mode,
    input  logic [albs_pkg::MENU_W-1:0] i_menu_state,
    input  logic                        i_key_ack,
    input  logic                        i_tone_start,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic                        i_light_on,
    input  logic                        i_buzzer_on,
    input  logic                        i_muted,
    input  logic                        i_tone_busy,
    output int                          o_pending,
    output int                          o_fail_count
);
    import albs_pkg::*;

    typedef struct packed {
        logic light_on;
        logic buzzer_on;
        logic muted;
        logic tone_busy;
    } t_levels;

    t_state  seq;
    t_cfg    regs;
    t_levels expected_levels[$];
    int      fails = 0;

    // one blink phase step, shared by the sounding and silent alarms
    function automatic void blink_step(logic [MENU_W-1:0] menu);
        seq.tick_count = seq.tick_count + TICK_W'(1);
        if (seq.tick_count >= regs.phase_ticks) begin
            seq.tick_count  = '0;
            seq.phase_count = seq.phase_count + PHASE_W'(1);
            if (seq.mute_active) begin
                seq.mute_phase_count = seq.mute_phase_count + MUTE_W'(1);
                if (seq.mute_phase_count >= regs.mute_phases) begin
                    seq.mute_phase_count = '0;
                    seq.mute_active      = 1'b0;
                end
            end
        end
        seq.light_level = !(!seq.phase_count[0] && menu == MENU_HOME && !seq.mute_active);
    endfunction

    function automatic t_levels tick_sequencer(t_tick t);
        if (t.key_ack)
            seq.mute_active = 1'b1;
        if (t.tone_start)
            seq.tone_active = 1'b1;
        case (t.alarm_mode)
            MODE_SOUNDING: begin
                blink_step(t.menu_state);
                if (seq.phase_count == PHASE_BUZZ_ON)
                    seq.buzzer_level = 1'b1;
                else if (seq.phase_count == PHASE_BUZZ_OFF)
                    seq.buzzer_level = 1'b0;
                if (seq.phase_count == PHASE_LAST)
                    seq.phase_count = '0;
            end
            MODE_SILENT: begin
                blink_step(t.menu_state);
                if (seq.phase_count == PHASE_LAST)
                    seq.phase_count = '0;
                seq.buzzer_level = 1'b0;
            end
            MODE_SLOW: begin
                seq.slow_count = seq.slow_count + TICK_W'(1);
                if (seq.slow_count > regs.slow_on) begin
                    seq.buzzer_level = 1'b1;
                    seq.light_level  = 1'b0;
                end
                if (seq.slow_count > regs.slow_period) begin
                    seq.buzzer_level = 1'b0;
                    seq.light_level  = 1'b1;
                    seq.slow_count   = '0;
                end
            end
            default: begin
                if (seq.tone_active) begin
                    seq.tick_count   = seq.tick_count + TICK_W'(1);
                    seq.buzzer_level = 1'b1;
                    if (seq.tick_count > regs.tone_ticks) begin
                        seq.buzzer_level = 1'b0;
                        seq.tick_count   = '0;
                        seq.tone_active  = 1'b0;
                    end
                end else begin
                    seq.light_level  = 1'b1;
                    seq.buzzer_level = 1'b0;
                    seq.tick_count   = '0;
                end
            end
        endcase
        return '{seq.light_level, seq.buzzer_level, seq.mute_active, seq.tone_active};
    endfunction

    function automatic int check_bit(string field, logic want, logic got);
        if (want === got)
            return 0;
        $error("%s: expected %0b, got %0b", field, want, got);
        return 1;
    endfunction

    always @(posedge i_clk) begin
        t_levels want;
        if (!i_rst_n) begin
            seq = '{tick_count: '0, phase_count: '0, mute_phase_count: '0, slow_count: '0,
                    mute_active: 1'b0, tone_active: 1'b0, light_level: 1'b1,
                    buzzer_level: 1'b0};
            regs = '{phase_ticks: RST_PHASE_TICKS, mute_phases: RST_MUTE_PHASES,
                     tone_ticks: RST_TONE_TICKS, slow_on: RST_SLOW_ON,
                     slow_period: RST_SLOW_PERIOD};
            expected_levels.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (t_cfg_idx'(i_cfg_addr))
                    REG_PHASE_TICKS: regs.phase_ticks = i_cfg_wdata;
                    REG_MUTE_PHASES: regs.mute_phases = i_cfg_wdata[MUTE_W-1:0];
                    REG_TONE_TICKS:  regs.tone_ticks  = i_cfg_wdata;
                    REG_SLOW_ON:     regs.slow_on     = i_cfg_wdata;
                    REG_SLOW_PERIOD: regs.slow_period = i_cfg_wdata;
                    default: ;
                endcase
            end
            // results leave only after their beat has passed both registers, so compare before predicting
            if (i_out_valid && i_out_ready) begin
                if (expected_levels.size() == 0) begin
                    $error("result beat with no expectation waiting");
                    fails++;
                end else begin
                    want = expected_levels.pop_front();
                    fails += check_bit("light_on", want.light_on, i_light_on);
                    fails += check_bit("buzzer_on", want.buzzer_on, i_buzzer_on);
                    fails += check_bit("muted", want.muted, i_muted);
                    fails += check_bit("tone_busy", want.tone_busy, i_tone_busy);
                end
            end
            if (i_in_valid && i_in_ready)
                expected_levels.push_back(
                    tick_sequencer({i_alarm_mode, i_menu_state, i_key_ack, i_tone_start}));
        end
        o_pending    <= expected_levels.size();
        o_fail_count <= fails;
    end

endmodule

>>> dv/alarm_light_buzzer_sequencer_tb.sv
// testbench top for the alarm light and buzzer sequencer: stimulus, flow control and verdict
`timescale 1ns / 1ps

module alarm_light_buzzer_sequencer_tb;
    import albs_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int IDLE_PERCENT   = 27;
    localparam int OUT_HOLD       = 150;
    localparam logic [MENU_W-1:0] MENU_ZERO = '0;
    localparam logic [MENU_W-1:0] MENU_FULL = '1;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              cfg_wr_en   = 1'b0;
    logic [CFG_AW-1:0] cfg_addr    = '0;
    logic [CFG_DW-1:0] cfg_wdata   = '0;
    logic              in_valid    = 1'b0;
    t_tick             tick_drv    = '0;
    logic              out_ready   = 1'b0;
    logic              in_ready;
    logic              out_valid;
    logic              light_on;
    logic              buzzer_on;
    logic              muted;
    logic              tone_busy;
    int                pending;
    int                fail_count;
    int                idle_cycles = 0;
    bit                calm        = 1'b0;
    bit                hold_req    = 1'b0;
    logic [MODE_W-1:0] run_mode    = MODE_NONE;
    int                run_left    = 0;

    alarm_light_buzzer_sequencer i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_addr   (cfg_addr),
        .i_cfg_wdata  (cfg_wdata),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_alarm_mode (tick_drv.alarm_mode),
        .i_menu_state (tick_drv.menu_state),
        .i_key_ack    (tick_drv.key_ack),
        .i_tone_start (tick_drv.tone_start),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_light_on   (light_on),
        .o_buzzer_on  (buzzer_on),
        .o_muted      (muted),
        .o_tone_busy  (tone_busy)
    );

    albs_level_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_addr   (cfg_addr),
        .i_cfg_wdata  (cfg_wdata),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_alarm_mode (tick_drv.alarm_mode),
        .i_menu_state (tick_drv.menu_state),
        .i_key_ack    (tick_drv.key_ack),
        .i_tone_start (tick_drv.tone_start),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_light_on   (light_on),
        .i_buzzer_on  (buzzer_on),
        .i_muted      (muted),
        .i_tone_busy  (tone_busy),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // result side: random back-pressure plus one long hold on request
    initial begin
        int hold;
        bit hold_done;
        hold      = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                hold      = OUT_HOLD;
                hold_done = 1'b1;
            end
            if (hold != 0) begin
                hold--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
            end
        end
    end

    task automatic send_tick(input t_tick t);
        int gap;
        gap = 0;
        while (!calm && $urandom_range(99) < IDLE_PERCENT)
            gap++;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        tick_drv <= t;
        do
            @(posedge i_clk);
        while (!(in_valid && in_ready));
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge i_clk);
    endtask

    // drain the block, then write every register and one unmapped index
    task automatic load_config(input t_cfg c);
        in_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (pending != 0);
        repeat (2) @(posedge i_clk);
        write_reg(REG_PHASE_TICKS, c.phase_ticks);
        write_reg(REG_MUTE_PHASES, CFG_DW'(c.mute_phases));
        write_reg(REG_TONE_TICKS, c.tone_ticks);
        write_reg(REG_SLOW_ON, c.slow_on);
        write_reg(REG_SLOW_PERIOD, c.slow_period);
        write_reg(CFG_AW'($urandom_range(2**CFG_AW - 1, int'(REG_SLOW_PERIOD) + 1)),
                  CFG_DW'($urandom));
        cfg_wr_en <= 1'b0;
    endtask

    // mostly runs of one mode with random content, some pure noise
    function automatic t_tick next_random_tick();
        t_tick t;
        if ($urandom_range(99) < 15) begin
            t.alarm_mode = MODE_W'($urandom_range(3));
            t.menu_state = MENU_W'($urandom_range(255));
            t.key_ack    = 1'($urandom_range(1));
            t.tone_start = 1'($urandom_range(1));
            return t;
        end
        if (run_left == 0) begin
            run_mode = MODE_W'($urandom_range(3));
            run_left = $urandom_range(40, 1);
        end
        run_left--;
        t.alarm_mode = run_mode;
        t.menu_state = ($urandom_range(99) < 65) ? MENU_HOME : MENU_W'($urandom_range(255));
        t.key_ack    = $urandom_range(99) < 6;
        t.tone_start = $urandom_range(99) < ((run_mode == MODE_NONE) ? 12 : 3);
        return t;
    endfunction

    initial begin
        t_cfg  c;
        t_tick directed[$];
        int    n;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero phase and mute registers, short tone and slow cycle
        c = '{phase_ticks: '0, mute_phases: '0, tone_ticks: 16'd2, slow_on: '0,
              slow_period: 16'd1};
        load_config(c);
        directed = '{
            {MODE_SOUNDING, MENU_HOME, 1'b0, 1'b0}, {MODE_SOUNDING, MENU_HOME, 1'b0, 1'b0},
            {MODE_SOUNDING, MENU_HOME, 1'b0, 1'b0}, {MODE_SOUNDING, MENU_HOME, 1'b0, 1'b0},
            {MODE_SOUNDING, MENU_HOME, 1'b0, 1'b0}, {MODE_SOUNDING, MENU_HOME, 1'b1, 1'b0},
            {MODE_SILENT, MENU_FULL, 1'b0, 1'b0},   {MODE_SILENT, MENU_HOME, 1'b1, 1'b0},
            {MODE_SILENT, MENU_ZERO, 1'b0, 1'b1},   {MODE_SLOW, MENU_HOME, 1'b0, 1'b0},
            {MODE_SLOW, MENU_FULL, 1'b0, 1'b0},     {MODE_SLOW, MENU_HOME, 1'b1, 1'b1},
            {MODE_NONE, MENU_HOME, 1'b0, 1'b0},     {MODE_NONE, MENU_ZERO, 1'b0, 1'b0},
            {MODE_NONE, MENU_FULL, 1'b0, 1'b0},     {MODE_NONE, MENU_HOME, 1'b0, 1'b0},
            {MODE_NONE, MENU_HOME, 1'b1, 1'b1},     {MODE_NONE, MENU_FULL, 1'b0, 1'b0},
            {MODE_NONE, MENU_ZERO, 1'b0, 1'b0},     {MODE_NONE, MENU_ZERO, 1'b0, 1'b0}
        };
        foreach (directed[i])
            send_tick(directed[i]);

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: c = '{phase_ticks: RST_PHASE_TICKS, mute_phases: RST_MUTE_PHASES,
                         tone_ticks: RST_TONE_TICKS, slow_on: RST_SLOW_ON,
                         slow_period: RST_SLOW_PERIOD};
                1: c = '{phase_ticks: '1, mute_phases: '1, tone_ticks: '1, slow_on: '1,
                         slow_period: '1};
                2: c = '{phase_ticks: 16'd1, mute_phases: 8'd1, tone_ticks: 16'd1,
                         slow_on: '0, slow_period: 16'd1};
                default: c = '{phase_ticks: TICK_W'($urandom_range(4, 1)),
                               mute_phases: MUTE_W'($urandom_range(3, 1)),
                               tone_ticks: TICK_W'($urandom_range(6, 1)),
                               slow_on: TICK_W'($urandom_range(5)),
                               slow_period: TICK_W'($urandom_range(8, 1))};
            endcase
            load_config(c);
            calm = (ph == 4);
            if (ph == 2)
                hold_req = 1'b1;
            n = (ph <= 1) ? 60 : 140;
            repeat (n)
                send_tick(next_random_tick());
        end
        calm = 1'b0;

        in_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (pending != 0);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
